/* hdl/lfu_pkg.sv */
// Package with shared constants and types of the LFU cache table.
`default_nettype none
package lfu_pkg;
  localparam int unsigned DepthDefault = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned StampW = 64;
  localparam int unsigned CapW = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic ModeGet = 1'b0;
  localparam logic ModePut = 1'b1;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

/* hdl/lfu_cache_table_unit.sv */
// Top level of the LFU cache table: memory scan, victim search and write-back.
// Each item is handled in turn: a scan of the entry memory (one entry read per cycle), a
// write-back of the entry and an output to the receiver; a new item is not taken before
// the last one has left.
// The result waits in an output register; the next item is taken once it is taken.
// Reset clears valid bits, occupancy, stamp counter and sets capacity to 16.
`default_nettype none
module lfu_cache_table_unit #(
  parameter int unsigned DEPTH = lfu_pkg::DepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // read_value[31:0], evicted[32], zero fill
  output logic             m_axis_tuser,   // hit
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);
  import lfu_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WRITE, S_OUT} state_e;

  entry_t mem_q [DEPTH];
  entry_t rd_q;
  logic [DEPTH-1:0] valid_q;
  state_e state_q;
  logic [CntW-1:0] scan_q;
  logic [IdxW-1:0] ridx_q;
  logic rvalid_q;
  logic mode_q;
  logic [KeyW-1:0] key_q;
  logic [DataW-1:0] val_q;
  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] occ_q;
  logic [StampW-1:0] stamp_q;
  logic found_q, vic_ok_q, free_ok_q;
  logic [IdxW-1:0] found_idx_q, vic_idx_q, free_idx_q;
  logic [CountW-1:0] vic_cnt_q;
  logic [StampW-1:0] vic_stamp_q;
  logic [DataW-1:0] found_data_q;
  logic [CountW-1:0] found_cnt_q;
  logic hit_q, ev_q;
  logic [DataW-1:0] rdv_q;

  logic [CntW-1:0] cap_eff;
  logic better;
  logic [IdxW-1:0] fidx;
  logic do_evict;
  logic do_insert;
  logic [DEPTH-1:0] valid_d;

  assign cap_eff = ({{(32-CapW){1'b0}}, cap_q} > DEPTH) ? CntW'(DEPTH)
                 : CntW'(cap_q);
  assign better = rvalid_q && valid_q[ridx_q] && (!vic_ok_q ||
                  rd_q.count < vic_cnt_q ||
                  (rd_q.count == vic_cnt_q && rd_q.stamp < vic_stamp_q));
  assign do_evict = (occ_q >= cap_eff) && vic_ok_q;
  assign do_insert = (mode_q == ModePut) && (cap_eff != '0) && !found_q &&
                     (do_evict || free_ok_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata = {7'd0, ev_q, rdv_q};
  assign m_axis_tuser = hit_q;

  // Entry memory: write-back of the updated or new entry, and synchronous read of the scanned entry.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE && mode_q == ModePut && cap_eff != '0) begin
      if (found_q) begin
        mem_q[found_idx_q] <= '{key: key_q, data: val_q,
          count: (found_cnt_q == CountMax) ? found_cnt_q : found_cnt_q + CountW'(1),
          stamp: stamp_q};
      end else begin
        mem_q[fidx] <= '{key: key_q, data: val_q, count: CountW'(1), stamp: stamp_q};
      end
    end else if (state_q == S_WRITE && mode_q == ModeGet && found_q) begin
      mem_q[found_idx_q] <= '{key: key_q, data: found_data_q,
        count: (found_cnt_q == CountMax) ? found_cnt_q : found_cnt_q + CountW'(1),
        stamp: stamp_q};
    end
    rd_q <= mem_q[scan_q[IdxW-1:0]];
  end

  // With a victim the written slot is the lower of the victim and the lowest invalid slot.
  always_comb begin
    fidx = free_idx_q;
    if (do_evict && (!free_ok_q || vic_idx_q < free_idx_q)) begin
      fidx = vic_idx_q;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (do_evict) valid_d[vic_idx_q] = 1'b0;
    valid_d[fidx] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      cap_q <= CapReset;
      occ_q <= '0;
      stamp_q <= '0;
      scan_q <= '0;
      ridx_q <= '0;
      rvalid_q <= 1'b0;
      found_q <= 1'b0;
      vic_ok_q <= 1'b0;
      free_ok_q <= 1'b0;
      hit_q <= 1'b0;
      ev_q <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode_q <= s_axis_tuser;
            key_q <= s_axis_tdata[31:0];
            val_q <= s_axis_tdata[63:32];
            scan_q <= CntW'(1);
            ridx_q <= '0;
            rvalid_q <= 1'b1;
            found_q <= 1'b0;
            vic_ok_q <= 1'b0;
            free_ok_q <= 1'b0;
            state_q <= (DEPTH == 1) ? S_LAST : S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (valid_q[ridx_q] && rd_q.key == key_q && !found_q) begin
            found_q <= 1'b1;
            found_idx_q <= ridx_q;
            found_data_q <= rd_q.data;
            found_cnt_q <= rd_q.count;
          end
          if (!valid_q[ridx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_idx_q <= ridx_q;
          end
          if (better) begin
            vic_ok_q <= 1'b1;
            vic_idx_q <= ridx_q;
            vic_cnt_q <= rd_q.count;
            vic_stamp_q <= rd_q.stamp;
          end
          ridx_q <= ridx_q + IdxW'(1);
          if (state_q == S_LAST) begin
            state_q <= S_WRITE;
          end else begin
            if (scan_q == CntW'(DEPTH - 1)) state_q <= S_LAST;
            scan_q <= scan_q + CntW'(1);
          end
        end
        S_WRITE: begin
          hit_q <= found_q;
          ev_q <= do_insert && do_evict;
          if (mode_q == ModeGet) begin
            rdv_q <= found_q ? found_data_q : '1;
          end else begin
            rdv_q <= '0;
          end
          if ((mode_q == ModeGet && found_q) || (mode_q == ModePut && cap_eff != '0)) begin
            stamp_q <= stamp_q + StampW'(1);
          end
          if (do_insert) begin
            valid_q <= valid_d;
            if (!do_evict) occ_q <= occ_q + CntW'(1);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state_q <= S_IDLE;
          scan_q <= '0;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q) else $error("occupancy mismatch");
  a_ev_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && ev_q) |-> mode_q == ModePut) else $error("evict on get");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !m_axis_tready) |=> $stable(rdv_q)) else $error("result moved");
endmodule
`default_nettype wire
